// ----- hw/rtl/scpa_pkg.sv -----
`default_nettype none
package scpa_pkg;

   localparam int NUM_CLASSES   = 128;
   localparam int POOL_GRANULES = 4096;

   localparam int ADDR_W    = 32;
   localparam int SIZE_W    = 13;
   localparam int CLS_W     = SIZE_W - 5;
   localparam int CLASS_AW  = $clog2(NUM_CLASSES);
   localparam int GRAN_W    = $clog2(POOL_GRANULES);
   localparam int STATUS_W  = 2;
   localparam int CSR_IDX_W = 1;

   localparam logic [ADDR_W-1:0] POOL_START_RST = 32'h0000_0000;
   localparam logic [ADDR_W-1:0] POOL_END_RST   = 32'h0001_0000;
   localparam logic [ADDR_W-1:0] ALIGN_ADD      = 32'h0000_000f;
   localparam logic [ADDR_W-1:0] ALIGN_MASK     = ~32'h0000_000f;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_POOL_START = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_POOL_END   = 1'b1;

   localparam logic [STATUS_W-1:0] STAT_REUSED  = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FRESH   = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_OOM     = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_TOO_BIG = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_HEAD,
      ST_LINK
   } state_type;

   typedef struct packed {
      logic load;
      logic finish_head;
      logic finish_pop;
   } ctrl_cmd_type;

   typedef struct packed {
      logic too_big;
      logic is_free;
      logic head_hit;
      logic out_free;
   } dp_stat_type;

endpackage
`default_nettype wire

// ----- hw/rtl/scpa_chan_if.sv -----
`default_nettype none
interface scpa_req_if
   import scpa_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic              req_type;
   logic [SIZE_W-1:0] size_bytes;
   logic [ADDR_W-1:0] block_address;

   modport source (output valid, req_type, size_bytes, block_address, input ready);
   modport sink   (input valid, req_type, size_bytes, block_address, output ready);
endinterface

interface scpa_rsp_if
   import scpa_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [ADDR_W-1:0]   result_address;
   logic [STATUS_W-1:0] status;
   logic [ADDR_W-1:0]   bytes_handed_out;
   logic [ADDR_W-1:0]   bytes_remaining;
   logic [ADDR_W-1:0]   high_water;

   modport source (output valid, result_address, status, bytes_handed_out,
                   bytes_remaining, high_water, input ready);
   modport sink   (input valid, result_address, status, bytes_handed_out,
                   bytes_remaining, high_water, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/scpa_ram.sv -----
`default_nettype none
module scpa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/scpa_ctrl.sv -----
`default_nettype none
module scpa_ctrl
   import scpa_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire dp_stat_type  stat,
   output ctrl_cmd_type      cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_HEAD;
            end
         end
         ST_HEAD: begin
            // pop needs the link of the head block first
            if (!stat.too_big && !stat.is_free && stat.head_hit) begin
               state_in = ST_LINK;
            end else if (stat.out_free) begin
               cmd.finish_head = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         ST_LINK: begin
            if (stat.out_free) begin
               cmd.finish_pop = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

// ----- hw/rtl/scpa_datapath.sv -----
`default_nettype none
module scpa_datapath
   import scpa_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [ADDR_W-1:0]    csr_wdata,
   input  wire logic                 req_type,
   input  wire logic [SIZE_W-1:0]    size_bytes,
   input  wire logic [ADDR_W-1:0]    block_address,
   input  wire ctrl_cmd_type         cmd,
   output dp_stat_type               stat,
   scpa_rsp_if.source                rsp
);

   logic [ADDR_W-1:0]   pool_start_ff, pool_start_in;
   logic [ADDR_W-1:0]   pool_end_ff, pool_end_in;
   logic [ADDR_W-1:0]   cursor_ff, cursor_in;
   logic [ADDR_W-1:0]   handed_ff, handed_in;
   logic [ADDR_W-1:0]   remain_ff, remain_in;
   logic [ADDR_W-1:0]   hwm_ff, hwm_in;
   logic                is_free_ff;
   logic [CLS_W-1:0]    cls_ff;
   logic [ADDR_W-1:0]   addr_ff;
   logic [NUM_CLASSES-1:0] valid_ff, valid_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]   res_addr_ff, res_addr_in;
   logic [STATUS_W-1:0] res_stat_ff, res_stat_in;

   logic [SIZE_W-1:0]   size_m1;
   logic [CLS_W-1:0]    req_cls;
   logic [CLASS_AW-1:0] cls_idx;
   logic                too_big;
   logic                free_ok;
   logic [ADDR_W-1:0]   head_rdata, head_value, link_rdata;
   logic [CLASS_AW-1:0] head_raddr;
   logic                head_we;
   logic [ADDR_W-1:0]   head_wdata;
   logic                link_we;
   logic [CLS_W:0]      cls_p1;
   logic [ADDR_W-1:0]   block;
   logic [ADDR_W-1:0]   space;
   logic                oom;
   logic [ADDR_W-1:0]   aligned;
   logic [ADDR_W-1:0]   carve_end;

   function automatic logic [GRAN_W-1:0] granule(input logic [ADDR_W-1:0] a,
                                                 input logic [ADDR_W-1:0] base);
      logic [ADDR_W-1:0] d;
      d = a - base;
      return d[GRAN_W+3:4];
   endfunction

   assign size_m1 = size_bytes - SIZE_W'(1);
   assign req_cls = (size_bytes == '0) ? '0 : size_m1[SIZE_W-1:5];
   assign cls_idx = cls_ff[CLASS_AW-1:0];
   assign too_big = {1'b0, cls_ff} >= (CLS_W+1)'(NUM_CLASSES);

   assign head_raddr = cmd.load ? req_cls[CLASS_AW-1:0] : cls_idx;
   assign head_value = valid_ff[cls_idx] ? head_rdata : '0;
   assign free_ok    = !too_big && is_free_ff && (addr_ff != '0);

   assign cls_p1    = {1'b0, cls_ff} + (CLS_W+1)'(1);
   assign block     = ADDR_W'({cls_p1, 5'b0});
   assign space     = pool_end_ff - cursor_ff;
   assign oom       = space <= block;
   assign aligned   = (cursor_ff + ALIGN_ADD) & ALIGN_MASK;
   assign carve_end = aligned + block;

   assign head_we    = (cmd.finish_head && free_ok) || cmd.finish_pop;
   assign head_wdata = cmd.finish_pop ? link_rdata : addr_ff;
   assign link_we    = cmd.finish_head && free_ok;

   scpa_ram #(.WIDTH(ADDR_W), .DEPTH(NUM_CLASSES)) u_head_ram (
      .clock (clock),
      .we    (head_we),
      .waddr (cls_idx),
      .wdata (head_wdata),
      .raddr (head_raddr),
      .rdata (head_rdata)
   );

   scpa_ram #(.WIDTH(ADDR_W), .DEPTH(POOL_GRANULES)) u_link_ram (
      .clock (clock),
      .we    (link_we),
      .waddr (granule(addr_ff, pool_start_ff)),
      .wdata (head_value),
      .raddr (granule(head_value, pool_start_ff)),
      .rdata (link_rdata)
   );

   always_comb begin
      pool_start_in = pool_start_ff;
      pool_end_in   = pool_end_ff;
      cursor_in     = cursor_ff;
      handed_in     = handed_ff;
      remain_in     = remain_ff;
      hwm_in        = hwm_ff;
      valid_in      = valid_ff;
      res_addr_in   = res_addr_ff;
      res_stat_in   = res_stat_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;

      if (csr_we) begin
         case (csr_index)
            CSR_POOL_START: pool_start_in = csr_wdata;
            CSR_POOL_END:   pool_end_in   = csr_wdata;
            default: begin
            end
         endcase
         cursor_in = pool_start_in;
         hwm_in    = pool_start_in;
         handed_in = '0;
         remain_in = pool_end_in - pool_start_in;
      end

      if (cmd.finish_head) begin
         rsp_valid_in = 1'b1;
         if (too_big) begin
            res_addr_in = is_free_ff ? addr_ff : '0;
            res_stat_in = STAT_TOO_BIG;
         end else if (is_free_ff) begin
            res_addr_in = addr_ff;
            res_stat_in = STAT_FRESH;
            if (free_ok) begin
               valid_in[cls_idx] = 1'b1;
            end
         end else if (oom) begin
            res_addr_in = '0;
            res_stat_in = STAT_OOM;
         end else begin
            cursor_in   = carve_end;
            hwm_in      = carve_end;
            handed_in   = handed_ff + block;
            remain_in   = remain_ff - block;
            res_addr_in = aligned;
            res_stat_in = STAT_FRESH;
         end
      end

      if (cmd.finish_pop) begin
         rsp_valid_in      = 1'b1;
         valid_in[cls_idx] = 1'b1;
         res_addr_in       = head_value;
         res_stat_in       = STAT_REUSED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_start_ff <= POOL_START_RST;
         pool_end_ff   <= POOL_END_RST;
         cursor_ff     <= POOL_START_RST;
         handed_ff     <= '0;
         remain_ff     <= POOL_END_RST - POOL_START_RST;
         hwm_ff        <= POOL_START_RST;
         valid_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pool_start_ff <= pool_start_in;
         pool_end_ff   <= pool_end_in;
         cursor_ff     <= cursor_in;
         handed_ff     <= handed_in;
         remain_ff     <= remain_in;
         hwm_ff        <= hwm_in;
         valid_ff      <= valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_addr_ff <= res_addr_in;
      res_stat_ff <= res_stat_in;
      if (cmd.load) begin
         is_free_ff <= (req_type == REQ_FREE);
         cls_ff     <= req_cls;
         addr_ff    <= block_address;
      end
   end

   assign stat.too_big  = too_big;
   assign stat.is_free  = is_free_ff;
   assign stat.head_hit = head_value != '0;
   assign stat.out_free = !rsp_valid_ff || rsp.ready;

   assign rsp.valid            = rsp_valid_ff;
   assign rsp.result_address   = res_addr_ff;
   assign rsp.status           = res_stat_ff;
   assign rsp.bytes_handed_out = handed_ff;
   assign rsp.bytes_remaining  = remain_ff;
   assign rsp.high_water       = hwm_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/size_class_pool_allocator_top.sv -----
`default_nettype none
// Pool allocator with 32-byte size classes: an allocate item pops its class's
// free list or carves a 16-byte-aligned block from a bump cursor; a free item
// pushes the block onto its class's list, with the list link kept in a link
// memory indexed by the block's 16-byte granule. One result item per request.
// Free, carve and rejected items take an accept step, then a head memory
// read; a pop from a free list adds a link memory read fed by the head
// read. A waiting result holds the next item at its final step only.
// Writing pool_start or pool_end reloads the cursor and counters but keeps
// the free lists. No clearing pass is needed after reset.
module size_class_pool_allocator_top
   import scpa_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [ADDR_W-1:0]    csr_wdata,
   scpa_req_if.sink                  req_chan,
   scpa_rsp_if.source                rsp_chan
);

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   scpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   scpa_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_type      (req_chan.req_type),
      .size_bytes    (req_chan.size_bytes),
      .block_address (req_chan.block_address),
      .cmd           (cmd),
      .stat          (stat),
      .rsp           (rsp_chan)
   );

endmodule
`default_nettype wire
